>>> sv/ptal_pkg.sv
// Package for the presence auto-lock block: codes, config and state types, deadline compare function.
`default_nettype none
package ptal_pkg;

  localparam int unsigned IdW      = 48;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned TimeoutW = 31;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 48;

  localparam logic [TimeoutW-1:0] TimeoutReset = TimeoutW'(30000);

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_HEARTBEAT = 3'd1,
    OP_RADIO     = 3'd2,
    OP_LOCKSTATE = 3'd3,
    OP_RESTART   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_LOCK   = 2'd1,
    ACT_UNLOCK = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    CAUSE_NONE   = 2'd0,
    CAUSE_MANUAL = 2'd1,
    CAUSE_AWAY   = 2'd2
  } cause_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENABLE          = 2'd0,
    CFG_SELECTED_DEVICE = 2'd1,
    CFG_AWAY_TIMEOUT    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic                enable;
    logic [IdW-1:0]      selected_device;
    logic [TimeoutW-1:0] away_timeout_ms;
  } ptal_cfg_t;

  typedef struct packed {
    logic             radio_present;
    logic             seen_recently;
    logic [TimeW-1:0] away_deadline;
    cause_e           lock_cause;
  } ptal_state_t;

  typedef struct packed {
    logic [2:0]       op;
    logic [IdW-1:0]   sender_id;
    logic             present;
    logic             locked;
    logic [1:0]       lock_cause;
    logic [TimeW-1:0] now_ms;
  } ptal_item_t;

  // Deadline reached when (now - deadline) mod 2^32 has its top bit clear
  function automatic logic deadline_passed(logic [TimeW-1:0] now,
                                           logic [TimeW-1:0] deadline);
    logic [TimeW-1:0] diff;
    diff = now - deadline;
    return ~diff[TimeW-1];
  endfunction

endpackage
`default_nettype wire

>>> sv/ptal_if.sv
// Valid/ready channel interfaces for event items and result items.
`default_nettype none
interface ptal_evt_if import ptal_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [2:0]       op;
  logic [IdW-1:0]   sender_id;
  logic             present;
  logic             locked;
  logic [1:0]       lock_cause;
  logic [TimeW-1:0] now_ms;

  modport source (output valid, op, sender_id, present, locked, lock_cause, now_ms,
                  input ready);
  modport sink (input valid, op, sender_id, present, locked, lock_cause, now_ms,
                output ready);
endinterface

interface ptal_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic       online;

  modport source (output valid, action, online, input ready);
  modport sink (input valid, action, online, output ready);
endinterface
`default_nettype wire

>>> sv/ptal_step.sv
// Per-event update: next state, action and online flag for one item.
`default_nettype none
module ptal_step import ptal_pkg::*; (
  input  ptal_cfg_t   cfg_i,
  input  ptal_state_t state_i,
  input  ptal_item_t  item_i,
  output ptal_state_t state_o,
  output action_e     action_o,
  output logic        online_o
);

  logic             match;
  logic [TimeW-1:0] rearm;
  action_e          arrival;

  assign match   = cfg_i.enable && (item_i.sender_id == cfg_i.selected_device);
  assign rearm   = item_i.now_ms + {1'b0, cfg_i.away_timeout_ms};
  assign arrival = (state_i.lock_cause == CAUSE_AWAY) ? ACT_UNLOCK : ACT_NONE;

  always_comb begin
    state_o  = state_i;
    action_o = ACT_NONE;
    case (item_i.op)
      OP_TICK: begin
        if (cfg_i.enable && !state_i.radio_present &&
            deadline_passed(item_i.now_ms, state_i.away_deadline)) begin
          state_o.seen_recently = 1'b0;
          if (state_i.lock_cause == CAUSE_NONE) begin
            action_o = ACT_LOCK;
          end
        end
      end
      OP_HEARTBEAT: begin
        if (match) begin
          state_o.seen_recently = 1'b1;
          state_o.away_deadline = rearm;
          action_o              = arrival;
        end
      end
      OP_RADIO: begin
        if (match) begin
          state_o.radio_present = item_i.present;
          state_o.away_deadline = rearm;
          if (item_i.present) begin
            state_o.seen_recently = 1'b1;
            action_o              = arrival;
          end
        end
      end
      OP_LOCKSTATE: begin
        if (!item_i.locked) begin
          state_o.lock_cause = CAUSE_NONE;
        end else begin
          case (item_i.lock_cause)
            CAUSE_NONE:   state_o.lock_cause = CAUSE_NONE;
            CAUSE_AWAY:   state_o.lock_cause = CAUSE_AWAY;
            default:      state_o.lock_cause = CAUSE_MANUAL;
          endcase
        end
      end
      OP_RESTART: begin
        state_o.radio_present = 1'b0;
        state_o.seen_recently = 1'b0;
        state_o.away_deadline = cfg_i.enable ? rearm : '0;
      end
      default: ;
    endcase
  end

  assign online_o = cfg_i.enable && (state_o.radio_present ||
                    (state_o.seen_recently &&
                     !deadline_passed(item_i.now_ms, state_o.away_deadline)));

endmodule
`default_nettype wire

>>> sv/presence_timeout_auto_lock.sv
// Presence auto-lock controller: input register, event update, result register.
//
// Usage:
//   evt_i carries one event item (op, sender_id, present, locked, lock_cause,
//   now_ms) under valid/ready. res_o returns exactly one result item (action,
//   online) per event, in order. Registers enable, selected_device and
//   away_timeout_ms are written through cfg_we_i/cfg_idx_i/cfg_wdata_i while
//   no events are in flight; index 3 is ignored.
//   Path: an accepted event is held in the input register; its result is
//   then registered and shown on res_o once the result register is free or
//   its item is being taken by res_o.
//   Throughput: one event per cycle while res_o is not held; the state update is an add, a wrapping
//   deadline compare and a few selects between the two registers.
//   Reset: asynchronous, active low; clears both stages, the presence state
//   and the lock cause, and loads the register reset values.
//   Stall: while res_o is held, the result holds and one more event waits in
//   the input register; evt_i.ready drops only when both are full.
`default_nettype none
module presence_timeout_auto_lock import ptal_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  ptal_evt_if.sink                 evt_i,
  ptal_res_if.source               res_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i
);

  ptal_cfg_t   cfg_q;
  ptal_state_t state_q, state_d;
  ptal_item_t  item_q;
  logic        in_vld_q;
  logic        out_vld_q;
  action_e     action_d;
  logic [1:0]  action_q;
  logic        online_d, online_q;
  logic        advance;

  assign advance     = in_vld_q && (!out_vld_q || res_o.ready);
  assign evt_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable          <= 1'b0;
      cfg_q.selected_device <= '0;
      cfg_q.away_timeout_ms <= TimeoutReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ENABLE:          cfg_q.enable          <= cfg_wdata_i[0];
        CFG_SELECTED_DEVICE: cfg_q.selected_device <= cfg_wdata_i[IdW-1:0];
        CFG_AWAY_TIMEOUT:    cfg_q.away_timeout_ms <= cfg_wdata_i[TimeoutW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (evt_i.ready) begin
      in_vld_q <= evt_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_i.valid && evt_i.ready) begin
      item_q.op         <= evt_i.op;
      item_q.sender_id  <= evt_i.sender_id;
      item_q.present    <= evt_i.present;
      item_q.locked     <= evt_i.locked;
      item_q.lock_cause <= evt_i.lock_cause;
      item_q.now_ms     <= evt_i.now_ms;
    end
  end

  ptal_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .action_o (action_d),
    .online_o (online_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.radio_present <= 1'b0;
      state_q.seen_recently <= 1'b0;
      state_q.away_deadline <= '0;
      state_q.lock_cause    <= CAUSE_NONE;
      out_vld_q             <= 1'b0;
    end else begin
      if (advance) begin
        state_q <= state_d;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      action_q <= action_d;
      online_q <= online_d;
    end
  end

  assign res_o.valid  = out_vld_q;
  assign res_o.action = action_q;
  assign res_o.online = online_q;

endmodule
`default_nettype wire

>>> sv/ptal_checker.sv
// Port-level checker for the presence auto-lock block, bound to the top level.
`default_nettype none
module ptal_checker import ptal_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                res_valid_i,
  input wire logic                res_ready_i,
  input wire logic [1:0]          res_action_i,
  input wire logic                res_online_i,
  input wire logic                cfg_we_i,
  input wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input wire logic [CfgDataW-1:0] cfg_wdata_i
);

  logic en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b0;
    end else if (cfg_we_i && (cfg_idx_i == CFG_ENABLE)) begin
      en_q <= cfg_wdata_i[0];
    end
  end

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=>
      res_valid_i && $stable(res_action_i) && $stable(res_online_i))
    else $error("result item changed while stalled");

  a_online_needs_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_online_i |-> en_q)
    else $error("online reported while feature disabled");

  a_action_needs_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_action_i != ACT_NONE) |-> en_q)
    else $error("lock or unlock action while feature disabled");

  a_action_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (res_action_i == ACT_NONE) || (res_action_i == ACT_LOCK) ||
                    (res_action_i == ACT_UNLOCK))
    else $error("undefined action code");

endmodule

bind presence_timeout_auto_lock ptal_checker u_ptal_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .res_action_i (res_o.action),
  .res_online_i (res_o.online),
  .cfg_we_i     (cfg_we_i),
  .cfg_idx_i    (cfg_idx_i),
  .cfg_wdata_i  (cfg_wdata_i)
);
`default_nettype wire
